>>> src/dps_pkg.sv
// Shared types and constants of the data poll scheduler.
package dps_pkg;

  localparam logic [7:0]  DEFAULT_FAST_POLLS  = 8'd8;
  localparam logic [15:0] MIN_POLL_PERIOD     = 16'd10;
  localparam logic [15:0] MIN_EXTERNAL_PERIOD = 16'd10;

  localparam int unsigned CfgDataW = 23;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 40;

  typedef enum logic [3:0] {
    OP_TICK     = 4'd0,
    OP_START    = 4'd1,
    OP_STOP     = 4'd2,
    OP_SENT     = 4'd3,
    OP_TIMEOUT  = 4'd4,
    OP_FRAME    = 4'd5,
    OP_ATTACH   = 4'd6,
    OP_FAST     = 4'd7,
    OP_EXTERNAL = 4'd8,
    OP_RECALC   = 4'd9
  } op_e;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_INVALID_STATE = 3'd1,
    ST_ALREADY       = 3'd2,
    ST_NO_BUFS       = 3'd3,
    ST_INVALID_ARGS  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    TX_OK      = 2'd0,
    TX_CCA_ERR = 2'd1
  } tx_status_e;

  typedef enum logic [2:0] {
    CFG_CHILD_TIMEOUT = 3'd0,
    CFG_ATTACH_PERIOD = 3'd1,
    CFG_RETX_PERIOD   = 3'd2,
    CFG_NOBUF_PERIOD  = 3'd3,
    CFG_FAST_PERIOD   = 3'd4,
    CFG_MAX_RETX      = 3'd5,
    CFG_QUICK_LIMIT   = 3'd6,
    CFG_MAX_FAST      = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic        buffer_ok;
    logic        poll_queued;
    logic        parent_valid;
    logic        rx_on_when_idle;
    logic [31:0] external_period;
    logic [7:0]  fast_poll_count;
    logic        attach_flag;
    logic        frame_pending;
    logic [1:0]  tx_status;
    logic [3:0]  operation;
  } item_t;

  typedef struct packed {
    logic        timer_active;
    logic        polling_enabled;
    logic [31:0] current_period;
    logic [2:0]  status;
    logic        poll_issued;
  } result_t;

endpackage

>>> src/data_poll_scheduler.sv
// Data poll scheduler for a sleepy end device: event decode, mode state and poll timer.
// Throughput: one item per cycle while results are taken; a held result stalls the input side.
// The whole state update is one pass between the two registers, item and result.
// The derived default period is registered and follows a configuration register in the cycle after it changes.
// Reset: all mode flags, counters, the timer and the period clear to zero; configuration
// registers return to their documented defaults.
module data_poll_scheduler
  import dps_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tx_status[1:0], frame_pending, attach_flag, fast_poll_count[7:0], external_period[31:0],
  // rx_on_when_idle, parent_valid, poll_queued, buffer_ok
  input  logic [InDataW-1:0]  s_axis_tdata,
  // operation[3:0]
  input  logic [3:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // poll_issued, status[2:0], current_period[31:0], polling_enabled, timer_active, zero pad
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // configuration
  logic [22:0] child_timeout_q;
  logic [15:0] attach_period_q, retx_period_q, nobuf_period_q, fast_period_q;
  logic [7:0]  max_retx_q, quick_limit_q, max_fast_q;
  logic [31:0] default_period_q, default_period_d;

  // state
  logic        enabled_q, attach_q, retx_q, nobuf_q, timer_running_q;
  logic [7:0]  tx_fail_q, timeout_cnt_q, fast_rem_q;
  logic [31:0] ext_period_q, poll_period_q, now_q, timer_start_q;

  logic        enabled_d, attach_d, retx_d, nobuf_d, timer_running_d;
  logic [7:0]  tx_fail_d, timeout_cnt_d, fast_rem_d;
  logic [31:0] ext_period_d, poll_period_d, now_d, timer_start_d;

  // pipeline
  logic    in_valid_q, out_valid_q, advance;
  item_t   item_q;
  result_t res_q, res_d;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - $bits(result_t)){1'b0}}, res_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      child_timeout_q <= 23'd240;
      attach_period_q <= 16'd100;
      retx_period_q   <= 16'd1000;
      nobuf_period_q  <= 16'd200;
      fast_period_q   <= 16'd188;
      max_retx_q      <= 8'd5;
      quick_limit_q   <= 8'd5;
      max_fast_q      <= 8'd15;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_CHILD_TIMEOUT: child_timeout_q <= cfg_data_i;
        CFG_ATTACH_PERIOD: attach_period_q <= cfg_data_i[15:0];
        CFG_RETX_PERIOD:   retx_period_q   <= cfg_data_i[15:0];
        CFG_NOBUF_PERIOD:  nobuf_period_q  <= cfg_data_i[15:0];
        CFG_FAST_PERIOD:   fast_period_q   <= cfg_data_i[15:0];
        CFG_MAX_RETX:      max_retx_q      <= cfg_data_i[7:0];
        CFG_QUICK_LIMIT:   quick_limit_q   <= cfg_data_i[7:0];
        CFG_MAX_FAST:      max_fast_q      <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // child_timeout * 1000 - retx_period * max_retx, saturated both ways
  always_comb begin
    logic [32:0] timeout_ms;
    logic [23:0] retx_total;
    logic [32:0] diff;
    timeout_ms = {child_timeout_q, 10'd0} - {6'd0, child_timeout_q, 4'd0}
               - {7'd0, child_timeout_q, 3'd0};
    retx_total = {8'd0, retx_period_q} * {16'd0, max_retx_q};
    diff = (timeout_ms > {9'd0, retx_total}) ? timeout_ms - {9'd0, retx_total} : 33'd0;
    if (diff[32]) begin
      default_period_d = '1;
    end else if (diff[31:0] == 32'd0) begin
      default_period_d = {16'd0, MIN_POLL_PERIOD};
    end else begin
      default_period_d = diff[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_period_q <= 32'd0;
    end else begin
      default_period_q <= default_period_d;
    end
  end

  function automatic logic [31:0] lower_of(logic [31:0] cur, logic [31:0] cand);
    return (cur == 32'd0 || cur > cand) ? cand : cur;
  endfunction

  always_comb begin
    logic        do_poll, do_sched, recalc, rc;
    logic [7:0]  n;
    logic [31:0] p;
    op_e         op;
    enabled_d       = enabled_q;
    attach_d        = attach_q;
    retx_d          = retx_q;
    nobuf_d         = nobuf_q;
    timer_running_d = timer_running_q;
    tx_fail_d       = tx_fail_q;
    timeout_cnt_d   = timeout_cnt_q;
    fast_rem_d      = fast_rem_q;
    ext_period_d    = ext_period_q;
    poll_period_d   = poll_period_q;
    now_d           = now_q;
    timer_start_d   = timer_start_q;
    do_poll         = 1'b0;
    do_sched        = 1'b0;
    recalc          = 1'b0;
    rc              = 1'b0;
    n               = 8'd0;
    p               = 32'd0;
    res_d           = '0;
    res_d.status    = ST_OK;
    op              = op_e'(item_q.operation);

    case (op)
      OP_TICK: begin
        now_d = now_q + 32'd1;
        if (timer_running_q && (now_d - timer_start_q) >= poll_period_q) begin
          timer_running_d = 1'b0;
          do_poll = 1'b1;
        end
      end
      OP_START: begin
        if (enabled_q) begin
          res_d.status = ST_ALREADY;
        end else if (item_q.rx_on_when_idle) begin
          res_d.status = ST_INVALID_STATE;
        end else begin
          enabled_d = 1'b1;
          do_sched  = 1'b1;
          recalc    = 1'b1;
        end
      end
      OP_STOP: begin
        timer_running_d = 1'b0;
        attach_d        = 1'b0;
        retx_d          = 1'b0;
        nobuf_d         = 1'b0;
        timeout_cnt_d   = 8'd0;
        tx_fail_d       = 8'd0;
        fast_rem_d      = 8'd0;
        enabled_d       = 1'b0;
      end
      OP_SENT: begin
        if (enabled_q) begin
          if (item_q.tx_status == TX_OK) begin
            if (fast_rem_q != 8'd0) begin
              fast_rem_d = fast_rem_q - 8'd1;
              rc = (fast_rem_d == 8'd0);
            end
            if (retx_q) begin
              retx_d    = 1'b0;
              tx_fail_d = 8'd0;
              rc        = 1'b1;
            end
          end else if (item_q.tx_status == TX_CCA_ERR) begin
            retx_d = 1'b1;
            rc     = 1'b1;
          end else begin
            tx_fail_d = tx_fail_q + 8'd1;
            if (tx_fail_d < max_retx_q) begin
              if (!retx_q) begin
                retx_d = 1'b1;
                rc     = 1'b1;
              end
            end else begin
              retx_d    = 1'b0;
              tx_fail_d = 8'd0;
              rc        = 1'b1;
            end
          end
          do_sched = rc;
          recalc   = rc;
        end
      end
      OP_TIMEOUT: begin
        if (enabled_q) begin
          timeout_cnt_d = timeout_cnt_q + 8'd1;
          if (timeout_cnt_d < quick_limit_q) begin
            do_poll = 1'b1;
          end else begin
            timeout_cnt_d = 8'd0;
          end
        end
      end
      OP_FRAME: begin
        if (enabled_q) begin
          timeout_cnt_d = 8'd0;
          do_poll = item_q.frame_pending;
        end
      end
      OP_ATTACH: begin
        if (attach_q != item_q.attach_flag) begin
          attach_d = item_q.attach_flag;
          do_sched = enabled_q;
          recalc   = enabled_q;
        end
      end
      OP_FAST: begin
        n = (item_q.fast_poll_count == 8'd0) ? DEFAULT_FAST_POLLS : item_q.fast_poll_count;
        if (n > max_fast_q) n = max_fast_q;
        if (fast_rem_q < n) fast_rem_d = n;
        do_sched = enabled_q && (fast_rem_q == 8'd0);
        recalc   = do_sched;
      end
      OP_EXTERNAL: begin
        if (item_q.external_period != 32'd0 &&
            item_q.external_period < {16'd0, MIN_EXTERNAL_PERIOD}) begin
          res_d.status = ST_INVALID_ARGS;
        end else if (ext_period_q != item_q.external_period) begin
          ext_period_d = item_q.external_period;
          do_sched = enabled_q;
          recalc   = enabled_q;
        end
      end
      OP_RECALC: begin
        do_sched = enabled_q;
        recalc   = enabled_q;
      end
      default: ;
    endcase

    if (do_poll) begin
      if (!enabled_q || item_q.rx_on_when_idle || !item_q.parent_valid) begin
        timer_running_d = 1'b0;
        attach_d        = 1'b0;
        retx_d          = 1'b0;
        nobuf_d         = 1'b0;
        timeout_cnt_d   = 8'd0;
        tx_fail_d       = 8'd0;
        fast_rem_d      = 8'd0;
        enabled_d       = 1'b0;
        res_d.status    = ST_INVALID_STATE;
      end else begin
        timer_running_d = 1'b0;
        do_sched = 1'b1;
        if (item_q.poll_queued) begin
          res_d.status = ST_ALREADY;
        end else if (!item_q.buffer_ok) begin
          nobuf_d      = 1'b1;
          recalc       = 1'b1;
          res_d.status = ST_NO_BUFS;
        end else begin
          res_d.poll_issued = 1'b1;
          if (nobuf_q) begin
            nobuf_d = 1'b0;
            recalc  = 1'b1;
          end
        end
      end
    end

    if (do_sched) begin
      if (recalc) begin
        if (attach_d) p = {16'd0, attach_period_q};
        if (retx_d) p = lower_of(p, {16'd0, retx_period_q});
        if (nobuf_d) p = lower_of(p, {16'd0, nobuf_period_q});
        if (fast_rem_d != 8'd0) p = lower_of(p, {16'd0, fast_period_q});
        if (ext_period_d != 32'd0) p = lower_of(p, ext_period_d);
        poll_period_d = (p == 32'd0) ? default_period_q : p;
      end
      if (!timer_running_d) timer_start_d = now_d;
      timer_running_d = 1'b1;
    end

    res_d.current_period  = poll_period_d;
    res_d.polling_enabled = enabled_d;
    res_d.timer_active    = timer_running_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q      <= 1'b0;
      out_valid_q     <= 1'b0;
      enabled_q       <= 1'b0;
      attach_q        <= 1'b0;
      retx_q          <= 1'b0;
      nobuf_q         <= 1'b0;
      timer_running_q <= 1'b0;
      tx_fail_q       <= 8'd0;
      timeout_cnt_q   <= 8'd0;
      fast_rem_q      <= 8'd0;
      ext_period_q    <= 32'd0;
      poll_period_q   <= 32'd0;
      now_q           <= 32'd0;
      timer_start_q   <= 32'd0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (advance) begin
        out_valid_q     <= 1'b1;
        enabled_q       <= enabled_d;
        attach_q        <= attach_d;
        retx_q          <= retx_d;
        nobuf_q         <= nobuf_d;
        timer_running_q <= timer_running_d;
        tx_fail_q       <= tx_fail_d;
        timeout_cnt_q   <= timeout_cnt_d;
        fast_rem_q      <= fast_rem_d;
        ext_period_q    <= ext_period_d;
        poll_period_q   <= poll_period_d;
        now_q           <= now_d;
        timer_start_q   <= timer_start_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) item_q <= {s_axis_tdata, s_axis_tuser};
    if (advance) res_q <= res_d;
  end

  // the timer only runs while polling is enabled
  assert property (@(posedge clk_i) disable iff (!rst_ni) timer_running_q |-> enabled_q)
    else $error("poll timer running while disabled");

  // a pending failure count implies retry mode
  assert property (@(posedge clk_i) disable iff (!rst_ni) (tx_fail_q != 8'd0) |-> retx_q)
    else $error("tx failure count without retry mode");

  // input side only stalls behind a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   !s_axis_tready |-> (out_valid_q && !m_axis_tready))
    else $error("input stalled without output backpressure");

  // an issued poll always reports success
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && res_q.poll_issued) |-> (res_q.status == ST_OK))
    else $error("poll issued with error status");

endmodule

>>> sim/data_poll_scheduler_test.sv
// Self-checking testbench for the data poll scheduler: directed table, then random phases.
`timescale 1ns / 1ps
module data_poll_scheduler_test;
  import dps_pkg::*;

  localparam logic [3:0] OP_FIRST_UNUSED = 4'd10;
  localparam logic [3:0] OP_LAST_UNUSED  = 4'd15;
  localparam logic [1:0] TX_OTHER_ERR    = 2'd2;
  localparam logic [1:0] TX_RESERVED     = 2'd3;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 85;
  localparam int MAX_GAP         = 8;
  localparam int DRAIN_CYCLES    = 20;
  localparam int LIMIT_NS        = 500000;
  localparam int ResW            = $bits(result_t);

  // buffer_ok is the top bit, tx_status the bottom two
  typedef struct packed {
    logic        buffer_ok;
    logic        poll_queued;
    logic        parent_valid;
    logic        rx_on_when_idle;
    logic [31:0] external_period;
    logic [7:0]  fast_poll_count;
    logic        attach_flag;
    logic        frame_pending;
    logic [1:0]  tx_status;
  } event_fields_t;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e     kind;
    logic [3:0]    op;
    event_fields_t f;
    cfg_idx_e      idx;
    logic [22:0]   val;
    bit            typed;
    result_t       res;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [3:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i;
  logic [2:0]          cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  data_poll_scheduler uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // scheduler shadow: configuration
  logic [22:0] child_timeout_s = 23'd240;
  logic [15:0] attach_ms       = 16'd100;
  logic [15:0] retx_ms         = 16'd1000;
  logic [15:0] nobuf_ms        = 16'd200;
  logic [15:0] fast_ms         = 16'd188;
  logic [7:0]  retx_limit      = 8'd5;
  logic [7:0]  quick_limit     = 8'd5;
  logic [7:0]  fast_clamp      = 8'd15;

  // scheduler shadow: state
  bit          en_q, attach_q, retx_q, nobuf_q, tmr_run;
  logic [7:0]  txfail_cnt = '0;
  logic [7:0]  tmo_cnt    = '0;
  logic [7:0]  fast_left  = '0;
  logic [31:0] ext_ms     = '0;
  logic [31:0] period_ms  = '0;
  logic [31:0] now_ms     = '0;
  logic [31:0] tmr_start  = '0;

  result_t expected_results[$];
  int      mismatches = 0;
  int      send_quiet = 0;
  int      recv_quiet = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #(LIMIT_NS);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [31:0] lower_nonzero(logic [31:0] cur, logic [31:0] cand);
    return (cur == 0 || cur > cand) ? cand : cur;
  endfunction

  function automatic logic [31:0] derived_period();
    logic [31:0] p;
    logic [63:0] a, b, d;
    p = '0;
    if (attach_q) p = 32'(attach_ms);
    if (retx_q) p = lower_nonzero(p, 32'(retx_ms));
    if (nobuf_q) p = lower_nonzero(p, 32'(nobuf_ms));
    if (fast_left != 0) p = lower_nonzero(p, 32'(fast_ms));
    if (ext_ms != 0) p = lower_nonzero(p, ext_ms);
    if (p == 0) begin
      a = 64'(child_timeout_s) * 64'd1000;
      b = 64'(retx_ms) * 64'(retx_limit);
      d = (a > b) ? a - b : 64'd0;
      p = (d > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : d[31:0];
      if (p == 0) p = 32'(MIN_POLL_PERIOD);
    end
    return p;
  endfunction

  task automatic rearm(input bit recompute);
    if (recompute) period_ms = derived_period();
    if (!tmr_run) tmr_start = now_ms;
    tmr_run = 1'b1;
  endtask

  task automatic halt_polling();
    tmr_run = 1'b0;
    attach_q = 1'b0;
    retx_q = 1'b0;
    nobuf_q = 1'b0;
    tmo_cnt = '0;
    txfail_cnt = '0;
    fast_left = '0;
    en_q = 1'b0;
  endtask

  task automatic attempt_poll(input event_fields_t f, output status_e st, output bit issued);
    issued = 1'b0;
    if (!en_q || f.rx_on_when_idle || !f.parent_valid) begin
      halt_polling();
      st = ST_INVALID_STATE;
    end else begin
      tmr_run = 1'b0;
      if (f.poll_queued) begin
        rearm(1'b0);
        st = ST_ALREADY;
      end else if (!f.buffer_ok) begin
        nobuf_q = 1'b1;
        rearm(1'b1);
        st = ST_NO_BUFS;
      end else begin
        issued = 1'b1;
        st = ST_OK;
        if (nobuf_q) begin
          nobuf_q = 1'b0;
          rearm(1'b1);
        end else begin
          rearm(1'b0);
        end
      end
    end
  endtask

  task automatic step_model(input logic [3:0] op, input event_fields_t f, output result_t r);
    bit         issued;
    bit         rc;
    status_e    st;
    logic [7:0] want_fast;
    issued = 1'b0;
    st = ST_OK;
    case (op)
      OP_TICK: begin
        now_ms = now_ms + 32'd1;
        if (tmr_run && (now_ms - tmr_start) >= period_ms) begin
          tmr_run = 1'b0;
          attempt_poll(f, st, issued);
        end
      end
      OP_START: begin
        if (en_q) st = ST_ALREADY;
        else if (f.rx_on_when_idle) st = ST_INVALID_STATE;
        else begin
          en_q = 1'b1;
          rearm(1'b1);
        end
      end
      OP_STOP: halt_polling();
      OP_SENT: begin
        if (en_q) begin
          rc = 1'b0;
          if (f.tx_status == TX_OK) begin
            if (fast_left != 0) begin
              fast_left = fast_left - 8'd1;
              rc = (fast_left == 0);
            end
            if (retx_q) begin
              retx_q = 1'b0;
              txfail_cnt = '0;
              rc = 1'b1;
            end
          end else if (f.tx_status == TX_CCA_ERR) begin
            retx_q = 1'b1;
            rc = 1'b1;
          end else begin
            txfail_cnt = txfail_cnt + 8'd1;
            if (txfail_cnt < retx_limit) begin
              if (!retx_q) begin
                retx_q = 1'b1;
                rc = 1'b1;
              end
            end else begin
              retx_q = 1'b0;
              txfail_cnt = '0;
              rc = 1'b1;
            end
          end
          if (rc) rearm(1'b1);
        end
      end
      OP_TIMEOUT: begin
        if (en_q) begin
          tmo_cnt = tmo_cnt + 8'd1;
          if (tmo_cnt < quick_limit) attempt_poll(f, st, issued);
          else tmo_cnt = '0;
        end
      end
      OP_FRAME: begin
        if (en_q) begin
          tmo_cnt = '0;
          if (f.frame_pending) attempt_poll(f, st, issued);
        end
      end
      OP_ATTACH: begin
        if (attach_q != f.attach_flag) begin
          attach_q = f.attach_flag;
          if (en_q) rearm(1'b1);
        end
      end
      OP_FAST: begin
        rc = (fast_left == 0);
        want_fast = (f.fast_poll_count == 0) ? DEFAULT_FAST_POLLS : f.fast_poll_count;
        if (want_fast > fast_clamp) want_fast = fast_clamp;
        if (fast_left < want_fast) fast_left = want_fast;
        if (en_q && rc) rearm(1'b1);
      end
      OP_EXTERNAL: begin
        if (f.external_period != 0 && f.external_period < 32'(MIN_EXTERNAL_PERIOD)) begin
          st = ST_INVALID_ARGS;
        end else if (ext_ms != f.external_period) begin
          ext_ms = f.external_period;
          if (en_q) rearm(1'b1);
        end
      end
      OP_RECALC: if (en_q) rearm(1'b1);
      default: ;
    endcase
    r.poll_issued     = issued;
    r.status          = st;
    r.current_period  = period_ms;
    r.polling_enabled = en_q;
    r.timer_active    = tmr_run;
  endtask

  function automatic event_fields_t ev(logic [1:0] tx, logic pend, logic att, logic [7:0] fcnt,
                                       logic [31:0] ext, logic rx, logic pv, logic pq,
                                       logic bok);
    event_fields_t f;
    f.tx_status       = tx;
    f.frame_pending   = pend;
    f.attach_flag     = att;
    f.fast_poll_count = fcnt;
    f.external_period = ext;
    f.rx_on_when_idle = rx;
    f.parent_valid    = pv;
    f.poll_queued     = pq;
    f.buffer_ok       = bok;
    return f;
  endfunction

  function automatic stim_row_t item_row(logic [3:0] op, event_fields_t f);
    stim_row_t row;
    row.kind  = ROW_ITEM;
    row.op    = op;
    row.f     = f;
    row.idx   = CFG_CHILD_TIMEOUT;
    row.val   = '0;
    row.typed = 1'b0;
    row.res   = '0;
    return row;
  endfunction

  // idle block: only the status field can be nonzero
  function automatic stim_row_t known_row(logic [3:0] op, event_fields_t f, status_e st);
    stim_row_t row;
    row = item_row(op, f);
    row.typed = 1'b1;
    row.res.status = st;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(cfg_idx_e idx, logic [22:0] val);
    stim_row_t row;
    row = item_row(OP_TICK, '0);
    row.kind = ROW_CFG;
    row.idx  = idx;
    row.val  = val;
    return row;
  endfunction

  function automatic int draw_gap(inout int quiet);
    int gap;
    if (quiet > 0) begin
      quiet--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, MAX_GAP);
      if ($urandom_range(0, 29) == 0) quiet = $urandom_range(10, 40);
    end
    return gap;
  endfunction

  task automatic flag(input string what, input logic [63:0] want, input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: mismatch in %s: expected %0h, got %0h", $time, what, want, got);
  endtask

  task automatic send_item(input logic [3:0] op, input event_fields_t f, input bit typed,
                           input result_t known);
    int      gap;
    result_t pred;
    gap = draw_gap(send_quiet);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= f;
    do @(posedge clk_i); while (!s_axis_tready);
    step_model(op, f, pred);
    expected_results.push_back(typed ? known : pred);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [22:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_CHILD_TIMEOUT: child_timeout_s = val;
      CFG_ATTACH_PERIOD: attach_ms = val[15:0];
      CFG_RETX_PERIOD:   retx_ms = val[15:0];
      CFG_NOBUF_PERIOD:  nobuf_ms = val[15:0];
      CFG_FAST_PERIOD:   fast_ms = val[15:0];
      CFG_MAX_RETX:      retx_limit = val[7:0];
      CFG_QUICK_LIMIT:   quick_limit = val[7:0];
      CFG_MAX_FAST:      fast_clamp = val[7:0];
      default: ;
    endcase
    repeat (2) @(posedge clk_i);
  endtask

  task automatic draw_event(output logic [3:0] op, output event_fields_t f);
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) op = OP_TICK;
    else if (r < 61) op = OP_START;
    else if (r < 63) op = OP_STOP;
    else if (r < 71) op = OP_SENT;
    else if (r < 77) op = OP_TIMEOUT;
    else if (r < 83) op = OP_FRAME;
    else if (r < 87) op = OP_ATTACH;
    else if (r < 91) op = OP_FAST;
    else if (r < 95) op = OP_EXTERNAL;
    else if (r < 98) op = OP_RECALC;
    else op = 4'($urandom_range(32'(OP_FIRST_UNUSED), 32'(OP_LAST_UNUSED)));
    f.tx_status       = 2'($urandom_range(0, 3));
    f.frame_pending   = 1'($urandom_range(0, 1));
    f.attach_flag     = 1'($urandom_range(0, 1));
    f.fast_poll_count = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
    case ($urandom_range(0, 5))
      0, 1: f.external_period = '0;
      2, 3: f.external_period = $urandom_range(32'(MIN_EXTERNAL_PERIOD), 40);
      4: f.external_period = $urandom_range(1, 32'(MIN_EXTERNAL_PERIOD) - 1);
      default: f.external_period = $urandom();
    endcase
    f.rx_on_when_idle = ($urandom_range(0, 11) == 0);
    f.parent_valid    = ($urandom_range(0, 11) != 0);
    f.poll_queued     = ($urandom_range(0, 7) == 0);
    f.buffer_ok       = ($urandom_range(0, 7) != 0);
  endtask

  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[ResW-1:0]);
      if (expected_results.size() == 0) begin
        flag("unexpected transfer", '0, 64'(m_axis_tdata));
      end else begin
        want = expected_results.pop_front();
        if (got.poll_issued !== want.poll_issued)
          flag("poll_issued", 64'(want.poll_issued), 64'(got.poll_issued));
        if (got.status !== want.status)
          flag("status", 64'(want.status), 64'(got.status));
        if (got.current_period !== want.current_period)
          flag("current_period", 64'(want.current_period), 64'(got.current_period));
        if (got.polling_enabled !== want.polling_enabled)
          flag("polling_enabled", 64'(want.polling_enabled), 64'(got.polling_enabled));
        if (got.timer_active !== want.timer_active)
          flag("timer_active", 64'(want.timer_active), 64'(got.timer_active));
        if (m_axis_tdata[OutDataW-1:ResW] !== '0)
          flag("pad bits", '0, 64'(m_axis_tdata[OutDataW-1:ResW]));
      end
    end
  end

  initial begin
    int gap;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = draw_gap(recv_quiet);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin
    stim_row_t     directed[$];
    logic [3:0]    op;
    event_fields_t f;
    event_fields_t up;
    logic [22:0]   regs[8];

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= CFG_CHILD_TIMEOUT;
    cfg_data_i    <= '0;

    up = ev(TX_OK, 0, 0, 8'd0, 32'd0, 0, 1, 0, 1);
    directed.push_back(known_row(OP_TICK, up, ST_OK));
    directed.push_back(known_row(OP_LAST_UNUSED, up, ST_OK));
    directed.push_back(known_row(OP_SENT, ev(TX_CCA_ERR, 0, 0, 0, 0, 0, 1, 0, 1), ST_OK));
    directed.push_back(known_row(OP_START, ev(TX_OK, 0, 0, 0, 0, 1, 1, 0, 1),
                                 ST_INVALID_STATE));
    directed.push_back(known_row(OP_EXTERNAL, ev(TX_OK, 0, 0, 0, 32'd1, 0, 1, 0, 1),
                                 ST_INVALID_ARGS));
    directed.push_back(known_row(OP_EXTERNAL,
                                 ev(TX_OK, 0, 0, 0, 32'(MIN_EXTERNAL_PERIOD) - 1, 0, 1, 0, 1),
                                 ST_INVALID_ARGS));
    directed.push_back(known_row(OP_EXTERNAL, ev(TX_OK, 0, 0, 0, 32'hFFFF_FFFF, 0, 1, 0, 1),
                                 ST_OK));
    directed.push_back(known_row(OP_EXTERNAL, up, ST_OK));
    directed.push_back(known_row(OP_ATTACH, ev(TX_OK, 0, 1, 0, 0, 0, 1, 0, 1), ST_OK));
    directed.push_back(known_row(OP_FAST, up, ST_OK));
    directed.push_back(item_row(OP_START, up));
    directed.push_back(item_row(OP_START, up));
    directed.push_back(item_row(OP_SENT, ev(TX_RESERVED, 0, 0, 0, 0, 0, 1, 0, 1)));
    directed.push_back(item_row(OP_SENT, ev(TX_OTHER_ERR, 0, 0, 0, 0, 0, 1, 0, 1)));
    directed.push_back(item_row(OP_SENT, ev(TX_CCA_ERR, 0, 0, 0, 0, 0, 1, 0, 1)));
    directed.push_back(item_row(OP_SENT, up));
    directed.push_back(item_row(OP_TIMEOUT, up));
    directed.push_back(item_row(OP_TIMEOUT, ev(TX_OK, 0, 0, 0, 0, 0, 1, 1, 1)));
    directed.push_back(item_row(OP_TIMEOUT, ev(TX_OK, 0, 0, 0, 0, 0, 1, 0, 0)));
    directed.push_back(item_row(OP_FAST, ev(TX_OK, 0, 0, 8'hFF, 0, 0, 1, 0, 1)));
    directed.push_back(item_row(OP_EXTERNAL,
                                ev(TX_OK, 0, 0, 0, 32'(MIN_EXTERNAL_PERIOD), 0, 1, 0, 1)));
    directed.push_back(item_row(OP_RECALC, up));
    directed.push_back(item_row(OP_FRAME, ev(TX_OK, 1, 0, 0, 0, 0, 0, 0, 1)));
    // default count above a low clamp
    directed.push_back(cfg_row(CFG_MAX_FAST, 23'd3));
    directed.push_back(item_row(OP_FAST, up));
    directed.push_back(item_row(OP_STOP, up));
    directed.push_back(item_row(OP_EXTERNAL, up));
    // default period saturating high, then at its minimum
    directed.push_back(cfg_row(CFG_CHILD_TIMEOUT, 23'h7FFFFF));
    directed.push_back(item_row(OP_START, up));
    directed.push_back(item_row(OP_STOP, up));
    directed.push_back(cfg_row(CFG_CHILD_TIMEOUT, 23'd0));
    directed.push_back(item_row(OP_START, up));
    directed.push_back(item_row(OP_STOP, up));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        settle();
        write_reg(directed[i].idx, directed[i].val);
      end else begin
        send_item(directed[i].op, directed[i].f, directed[i].typed, directed[i].res);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      if (ph == 0) begin
        regs = '{23'd4294967, 23'd65535, 23'd65535, 23'd65535, 23'd65535,
                 23'd255, 23'd255, 23'd255};
      end else if (ph == 1) begin
        // zero limits behave like one
        regs = '{23'd0, 23'd1, 23'd1, 23'd1, 23'd1, 23'd0, 23'd0, 23'd1};
      end else begin
        regs[CFG_CHILD_TIMEOUT] = ($urandom_range(0, 3) != 0) ? 23'd0 :
                                  23'($urandom_range(0, 4294967));
        for (int k = 32'(CFG_ATTACH_PERIOD); k <= 32'(CFG_FAST_PERIOD); k++)
          regs[k] = ($urandom_range(0, 7) == 0) ? 23'd65535 : 23'($urandom_range(1, 40));
        regs[CFG_MAX_RETX]    = 23'($urandom_range(1, 6));
        regs[CFG_QUICK_LIMIT] = 23'($urandom_range(1, 6));
        regs[CFG_MAX_FAST]    = ($urandom_range(0, 4) == 0) ? 23'($urandom_range(1, 7)) :
                                23'($urandom_range(8, 20));
      end
      foreach (regs[k]) write_reg(cfg_idx_e'(k), regs[k]);
      send_item(OP_START, up, 1'b0, '0);
      repeat (ITEMS_PER_PHASE - 1) begin
        draw_event(op, f);
        send_item(op, f, 1'b0, '0);
      end
    end

    settle();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/dps_pkg.sv
src/data_poll_scheduler.sv
sim/data_poll_scheduler_test.sv
